// ===== src/mtwg_pkg.sv =====
// Shared constants, codes, types and word functions of the MT19937 word generator.
package mtwg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int PTR_W        = 10;
    localparam int J_W          = 10;
    localparam int K_W          = 11;

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] KEY_SEED     = 32'd19650218;
    localparam logic [31:0] MIX1_MULT    = 32'd1664525;
    localparam logic [31:0] MIX2_MULT    = 32'd1566083941;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;

    localparam logic [1:0] REQ_SEED = 2'd0;
    localparam logic [1:0] REQ_KEY  = 2'd1;
    localparam logic [1:0] REQ_GEN  = 2'd2;

    typedef enum logic [2:0] {
        OP_SEED0 = 3'd0,
        OP_SEEDN = 3'd1,
        OP_ROT   = 3'd2,
        OP_COPY  = 3'd3,
        OP_MIX1  = 3'd4,
        OP_MIX2  = 3'd5,
        OP_HIGH  = 3'd6,
        OP_TWIST = 3'd7
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PTR_W-1:0] ptr;
        logic [J_W-1:0]   j_idx;
    } t_mix_ctl;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far_word);
        logic [31:0] y;
        y = {cur[31], nxt[30:0]};
        return far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    endfunction

endpackage

// ===== src/mtwg_cell.sv =====
// One state cell of the ring: a 32-bit word handed on to its neighbor on each step.
module mtwg_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);

    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// ===== src/mtwg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/mtwg_mix.sv =====
// Next-word unit: computes the word that enters the tail of the ring on a step.
module mtwg_mix (
    input  mtwg_pkg::t_mix_ctl i_ctl,
    input  logic [31:0]        i_seed,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_head,
    input  logic [31:0]        i_head_next,
    input  logic [31:0]        i_far,
    input  logic [31:0]        i_tail,
    output logic [31:0]        o_word
);
    import mtwg_pkg::*;

    logic [31:0] w_fold;
    logic [31:0] w_mult;
    logic [31:0] w_prod;
    logic [31:0] w_ptr;
    logic [31:0] w_j;

    assign w_fold = i_tail ^ (i_tail >> 30);
    assign w_ptr  = {{(32-PTR_W){1'b0}}, i_ctl.ptr};
    assign w_j    = {{(32-J_W){1'b0}}, i_ctl.j_idx};

    always_comb begin
        case (i_ctl.op)
            OP_MIX1: w_mult = MIX1_MULT;
            OP_MIX2: w_mult = MIX2_MULT;
            default: w_mult = SEED_MULT;
        endcase
    end

    assign w_prod = w_fold * w_mult;

    always_comb begin
        unique case (i_ctl.op)
            OP_SEED0: o_word = i_seed;
            OP_SEEDN: o_word = w_prod + w_ptr;
            OP_ROT:   o_word = i_head;
            OP_COPY:  o_word = i_tail;
            OP_MIX1:  o_word = (i_head ^ w_prod) + i_key + w_j;
            OP_MIX2:  o_word = (i_head ^ w_prod) - w_ptr;
            OP_HIGH:  o_word = HIGH_BIT;
            OP_TWIST: o_word = twist_word(i_head, i_head_next, i_far);
            default:  o_word = i_head;
        endcase
    end

endmodule

// ===== src/mt19937_word_generator_core.sv =====
// Top level of the MT19937 word generator: state ring, key store and sequencer.
//
// The 624-word generator state lives in a ring of cells that shifts toward cell 0, so that
// cell 0 always holds the word being worked on, cell 1 its successor, cell 397 the word
// the twist folds in, and cell 623 the word written last. A generate word is accepted, once
// the block is seeded and idle, in any cycle in which the output register is free or being
// emptied: it twists the head word, pushes the new word in at the tail and returns its
// tempered value, so generation runs at one word per cycle while the receiver takes each
// word, with no pause every 624 words; the path that sets this rate is the twist of cells
// 0, 1 and 397 plus the tempering into the output register. A seed word runs one ring step
// per state word through the shared multiplier in the next-word unit. The last key word
// starts the array initialization: a seeding pass, one alignment step, a first mixing pass
// with the key words and a second without them, one extra step each time the state index
// wraps, and a rotation that sets word 0 and brings it back to the head. While seeding or
// initializing the block accepts nothing. Key words go into a key memory that is read one
// word per mixing step; key words beyond its capacity are dropped. A generate word seen
// before any seeding is held off while the block seeds itself with 5489, and is then
// taken. Request kind 3 is accepted and ignored.
module mt19937_word_generator_core #(
    parameter int MAX_KEY_WORDS = 624
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_data_word,
    input  logic        i_last_key,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_random_word
);
    import mtwg_pkg::*;

    localparam int CW = $clog2(MAX_KEY_WORDS + 1);
    localparam int KW = $clog2(MAX_KEY_WORDS > 1 ? MAX_KEY_WORDS : 2);
    localparam logic [CW-1:0]    MAX_COUNT = CW'(MAX_KEY_WORDS);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(STATE_WORDS - 1);
    localparam logic [K_W-1:0]   PASS_LEN  = K_W'(STATE_WORDS);
    localparam logic [K_W-1:0]   PASS2_LEN = K_W'(STATE_WORDS - 1);

    // Sequencer phases.
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_SEED = 6'b000010,
        PH_KROT = 6'b000100,
        PH_MIX1 = 6'b001000,
        PH_MIX2 = 6'b010000,
        PH_FIN  = 6'b100000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [K_W-1:0]   r_k, n_k;
    logic [KW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_seed, n_seed;
    logic             r_key_mode, n_key_mode;
    logic             r_seeded, n_seeded;
    logic             r_fin0, n_fin0;
    logic             r_out_valid;
    logic [31:0]      r_out_word;

    logic             w_in_fire;
    logic             w_gen_fire;
    logic             w_auto_seed;
    logic             w_step;
    logic             w_wr_en;
    logic             w_stored;
    logic [K_W-1:0]   w_len_k;
    logic [CW:0]      w_j_inc;
    logic [KW-1:0]    w_j_wrap;
    t_op              w_op;
    t_mix_ctl         w_ctl;
    logic [31:0]      w_key;
    logic [31:0]      w_new;
    logic [31:0]      w_ring [STATE_WORDS];

    // The output register may take a new word when it is empty or being emptied.
    assign o_in_ready = (r_phase == PH_IDLE)
                     && !((i_req_type == REQ_GEN)
                          && (!r_seeded || (r_out_valid && !i_out_ready)));
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_gen_fire  = w_in_fire && (i_req_type == REQ_GEN);
    assign w_auto_seed = (r_phase == PH_IDLE) && i_in_valid
                      && (i_req_type == REQ_GEN) && !r_seeded;

    assign w_stored = (r_count < MAX_COUNT);
    assign w_len_k  = K_W'(n_len);
    assign w_j_inc  = (CW + 1)'(r_j) + 1'b1;
    assign w_j_wrap = (w_j_inc >= (CW + 1)'(r_len)) ? '0 : r_j + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_ptr      = r_ptr;
        n_k        = r_k;
        n_j        = r_j;
        n_len      = r_len;
        n_count    = r_count;
        n_seed     = r_seed;
        n_key_mode = r_key_mode;
        n_seeded   = r_seeded;
        n_fin0     = r_fin0;
        w_step     = 1'b0;
        w_op       = OP_ROT;
        w_wr_en    = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (w_auto_seed) begin
                    n_seed     = DEFAULT_SEED;
                    n_key_mode = 1'b0;
                    n_seeded   = 1'b1;
                    n_ptr      = '0;
                    n_phase    = PH_SEED;
                end else if (w_in_fire) begin
                    unique case (i_req_type)
                        REQ_SEED: begin
                            n_seed     = i_data_word;
                            n_key_mode = 1'b0;
                            n_seeded   = 1'b1;
                            n_ptr      = '0;
                            n_phase    = PH_SEED;
                        end
                        REQ_KEY: begin
                            if (w_stored) begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                            if (i_last_key) begin
                                n_len      = w_stored ? r_count + 1'b1 : r_count;
                                n_count    = '0;
                                n_seed     = KEY_SEED;
                                n_key_mode = 1'b1;
                                n_seeded   = 1'b1;
                                n_ptr      = '0;
                                n_j        = '0;
                                n_k        = (w_len_k > PASS_LEN) ? w_len_k : PASS_LEN;
                                n_phase    = PH_SEED;
                            end
                        end
                        REQ_GEN: begin
                            w_step = 1'b1;
                            w_op   = OP_TWIST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_SEED: begin
                w_step = 1'b1;
                w_op   = (r_ptr == '0) ? OP_SEED0 : OP_SEEDN;
                if (r_ptr == LAST_PTR) begin
                    n_phase = r_key_mode ? PH_KROT : PH_IDLE;
                end
            end
            PH_KROT: begin
                // Word 0 keeps its seeded value on the first pass.
                w_step  = 1'b1;
                w_op    = OP_ROT;
                n_j     = '0;
                n_phase = PH_MIX1;
            end
            PH_MIX1: begin
                w_step = 1'b1;
                if (r_ptr == '0) begin
                    // Index wrap: word 0 takes a copy of word 623.
                    w_op = OP_COPY;
                end else begin
                    w_op = OP_MIX1;
                    n_j  = w_j_wrap;
                    if (r_k == K_W'(1)) begin
                        n_k     = PASS2_LEN;
                        n_phase = PH_MIX2;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            PH_MIX2: begin
                w_step = 1'b1;
                if (r_ptr == '0) begin
                    w_op = OP_COPY;
                end else begin
                    w_op = OP_MIX2;
                    if (r_k == K_W'(1)) begin
                        n_fin0  = 1'b0;
                        n_phase = PH_FIN;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            PH_FIN: begin
                // Rotate until word 0 has been set and is back at the head.
                if ((r_ptr == '0) && r_fin0) begin
                    n_phase = PH_IDLE;
                end else begin
                    w_step = 1'b1;
                    if (r_ptr == '0) begin
                        w_op   = OP_HIGH;
                        n_fin0 = 1'b1;
                    end else begin
                        w_op = OP_ROT;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_step) begin
            n_ptr = (r_ptr == LAST_PTR) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ptr       <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_key_mode  <= 1'b0;
            r_seeded    <= 1'b0;
            r_fin0      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ptr      <= n_ptr;
            r_k        <= n_k;
            r_j        <= n_j;
            r_len      <= n_len;
            r_count    <= n_count;
            r_key_mode <= n_key_mode;
            r_seeded   <= n_seeded;
            r_fin0     <= n_fin0;
            if (w_gen_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
        if (w_gen_fire) begin
            r_out_word <= temper(w_new);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

    // Key memory; the read address is the next mixing index, so the registered read data match the current one.
    mtwg_ram #(
        .WIDTH(32),
        .DEPTH(MAX_KEY_WORDS)
    ) u_key_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[KW-1:0]),
        .i_wr_data(i_data_word),
        .i_rd_addr(n_j),
        .o_rd_data(w_key)
    );

    assign w_ctl.op    = w_op;
    assign w_ctl.ptr   = r_ptr;
    assign w_ctl.j_idx = J_W'(r_j);

    mtwg_mix u_mix (
        .i_ctl      (w_ctl),
        .i_seed     (r_seed),
        .i_key      (w_key),
        .i_head     (w_ring[0]),
        .i_head_next(w_ring[1]),
        .i_far      (w_ring[TWIST_OFFSET]),
        .i_tail     (w_ring[STATE_WORDS-1]),
        .o_word     (w_new)
    );

    // The state ring: each cell takes its upper neighbor's word, the tail takes the new word.
    for (genvar g = 0; g < STATE_WORDS; g++) begin : g_ring
        if (g == STATE_WORDS - 1) begin : g_tail
            mtwg_cell u_cell (
                .i_clk(i_clk),
                .i_en (w_step),
                .i_d  (w_new),
                .o_q  (w_ring[g])
            );
        end else begin : g_body
            mtwg_cell u_cell (
                .i_clk(i_clk),
                .i_en (w_step),
                .i_d  (w_ring[g+1]),
                .o_q  (w_ring[g])
            );
        end
    end

endmodule

// ===== bench/mt19937_word_generator_core_tb.sv =====
// Self-checking bench for the MT19937 word generator: random requests, predicted words.
module mt19937_word_generator_core_tb;
    import mtwg_pkg::*;

    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam int         KEY_CAP    = 624;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         DRAIN_CYC  = 40;
    localparam int         TWIST_GAP  = 397;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] data;
        logic        last;
    } t_mt_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = REQ_NONE;
    logic [31:0] i_data_word = '0;
    logic        i_last_key = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_random_word;

    mt19937_word_generator_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_data_word  (i_data_word),
        .i_last_key   (i_last_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_random_word(o_random_word)
    );

    always #5 i_clk = ~i_clk;

    // Predicted generator state.
    logic [31:0] gen_state [STATE_WORDS];
    int unsigned gen_pos;
    logic [31:0] key_words [KEY_CAP];
    int unsigned key_len;

    t_mt_req     pending_reqs[$];
    logic [31:0] expected_words[$];
    bit          any_failure = 0;
    bit          in_taken = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_pct = 100;
    int          cycle_cnt = 0;

    function automatic void fill_state(input logic [31:0] s);
        logic [31:0] p;
        gen_state[0] = s;
        for (int n = 1; n < STATE_WORDS; n++) begin
            p = gen_state[n-1];
            gen_state[n] = SEED_MULT * (p ^ (p >> 30)) + 32'(n);
        end
        gen_pos = STATE_WORDS;
    endfunction

    // Array initialization from the collected key words.
    function automatic void mix_key(input int unsigned len);
        int unsigned i, j, k;
        logic [31:0] p;
        i = 1;
        j = 0;
        fill_state(KEY_SEED);
        k = (len > STATE_WORDS) ? len : STATE_WORDS;
        for (; k > 0; k--) begin
            p = gen_state[i-1];
            gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 30)) * MIX1_MULT))
                           + key_words[j] + 32'(j);
            i++;
            j++;
            if (i >= STATE_WORDS) begin
                gen_state[0] = gen_state[STATE_WORDS-1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (k = STATE_WORDS - 1; k > 0; k--) begin
            p = gen_state[i-1];
            gen_state[i] = (gen_state[i] ^ ((p ^ (p >> 30)) * MIX2_MULT)) - 32'(i);
            i++;
            if (i >= STATE_WORDS) begin
                gen_state[0] = gen_state[STATE_WORDS-1];
                i = 1;
            end
        end
        gen_state[0] = HIGH_BIT;
        gen_pos = STATE_WORDS;
    endfunction

    function automatic void regenerate();
        logic [31:0] y;
        for (int n = 0; n < STATE_WORDS; n++) begin
            y = {gen_state[n][31], gen_state[(n + 1) % STATE_WORDS][30:0]};
            gen_state[n] = gen_state[(n + TWIST_GAP) % STATE_WORDS] ^ (y >> 1)
                           ^ (y[0] ? TWIST_MATRIX : 32'd0);
        end
        gen_pos = 0;
    endfunction

    function automatic void predict_request(input t_mt_req r);
        logic [31:0] y;
        case (r.kind)
            REQ_SEED: fill_state(r.data);
            REQ_KEY: begin
                if (key_len < KEY_CAP) begin
                    key_words[key_len] = r.data;
                    key_len++;
                end
                if (r.last) begin
                    mix_key(key_len);
                    key_len = 0;
                end
            end
            REQ_GEN: begin
                if (gen_pos >= STATE_WORDS) begin
                    // Never seeded: fall back to the default seed first.
                    if (gen_pos == STATE_WORDS + 1) fill_state(DEFAULT_SEED);
                    regenerate();
                end
                y = gen_state[gen_pos];
                gen_pos++;
                y = y ^ (y >> 11);
                y = y ^ ((y << 7) & TEMPER_B);
                y = y ^ ((y << 15) & TEMPER_C);
                y = y ^ (y >> 18);
                expected_words.push_back(y);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_req(input logic [1:0] kind, input logic [31:0] data,
                                      input logic last);
        t_mt_req r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        pending_reqs.push_back(r);
    endfunction

    // Input acceptance, prediction, output checks and the idle watchdog.
    always @(posedge i_clk) begin
        t_mt_req r;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            if (i_in_valid && o_in_ready) begin
                r.kind = i_req_type;
                r.data = i_data_word;
                r.last = i_last_key;
                predict_request(r);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("random_word: unexpected word, actual %h", o_random_word);
                    any_failure = 1;
                end else begin
                    if (o_random_word !== expected_words[0]) begin
                        $error("random_word: expected %h, actual %h",
                               expected_words[0], o_random_word);
                        any_failure = 1;
                    end
                    void'(expected_words.pop_front());
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else if (i_in_valid || pending_reqs.size() != 0 || expected_words.size() != 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** mt19937_word_generator_core: FAILED **");
                $finish;
            end
        end
    end

    // Sender: bursts of words separated by random gaps; payload held until taken.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_req_type  <= pending_reqs[0].kind;
                i_data_word <= pending_reqs[0].data;
                i_last_key  <= pending_reqs[0].last;
                void'(pending_reqs.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall density is redrawn from four levels, including stall-free stretches.
    always @(negedge i_clk) begin
        if (cycle_cnt % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
        end
        i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    initial begin
        int n, blk;
        gen_pos = STATE_WORDS + 1;
        key_len = 0;

        // Directed: generate before any seeding, ignored kind, seed extremes.
        queue_req(REQ_GEN, 32'hffff_ffff, 1'b1);
        queue_req(REQ_GEN, 32'h0, 1'b0);
        queue_req(REQ_NONE, 32'hffff_ffff, 1'b1);
        queue_req(REQ_SEED, 32'h0, 1'b0);
        queue_req(REQ_GEN, 32'h0, 1'b0);
        queue_req(REQ_SEED, 32'hffff_ffff, 1'b1);
        queue_req(REQ_GEN, 32'h1234_5678, 1'b1);
        // A single-word key, then a key with a seed in the middle of collection.
        queue_req(REQ_KEY, 32'hffff_ffff, 1'b1);
        queue_req(REQ_GEN, 32'h0, 1'b0);
        queue_req(REQ_KEY, 32'h0, 1'b0);
        queue_req(REQ_KEY, 32'h0000_0123, 1'b0);
        queue_req(REQ_SEED, 32'h8000_0000, 1'b0);
        queue_req(REQ_GEN, 32'h0, 1'b0);
        queue_req(REQ_KEY, 32'h0000_0234, 1'b0);
        queue_req(REQ_KEY, 32'h0000_0345, 1'b0);
        queue_req(REQ_KEY, 32'h0000_0456, 1'b1);
        queue_req(REQ_GEN, 32'h0, 1'b0);
        queue_req(REQ_GEN, 32'h0, 1'b0);

        // Overfull key store: the last mark still starts the initialization.
        for (n = 0; n < KEY_CAP + 2; n++)
            queue_req(REQ_KEY, $urandom(), (n == KEY_CAP + 1));
        for (n = 0; n < 4; n++) queue_req(REQ_GEN, $urandom(), $urandom_range(0, 1));

        // Long generate run from a seed so the state regenerates past its first block.
        queue_req(REQ_SEED, $urandom(), 1'b0);
        for (n = 0; n < 660; n++) queue_req(REQ_GEN, $urandom(), $urandom_range(0, 1));

        // Random mix: mostly generate runs, some seeds, short keys and ignored words.
        for (blk = 0; blk < 30; blk++) begin
            case ($urandom_range(0, 9))
                0: queue_req(REQ_SEED, $urandom(), $urandom_range(0, 1));
                1, 2: begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        queue_req(REQ_KEY, $urandom(), (k == n - 1));
                end
                3: queue_req(REQ_NONE, $urandom(), $urandom_range(0, 1));
                default: begin
                    n = $urandom_range(1, 30);
                    for (int k = 0; k < n; k++)
                        queue_req(REQ_GEN, $urandom(), $urandom_range(0, 1));
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !i_in_valid && expected_words.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (!any_failure && expected_words.size() == 0 && !o_out_valid)
            $display("** mt19937_word_generator_core: PASSED **");
        else
            $display("** mt19937_word_generator_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mtwg_pkg.sv
src/mtwg_cell.sv
src/mtwg_ram.sv
src/mtwg_mix.sv
src/mt19937_word_generator_core.sv
bench/mt19937_word_generator_core_tb.sv
